// File: src/plle_pkg.sv
// shared codes and control/status bundles for the linked list engine
`default_nettype none

package plle_pkg;

    // command codes carried in the input item
    localparam logic [2:0] CMD_INS_HEAD = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL = 3'd1;
    localparam logic [2:0] CMD_INS_POS  = 3'd2;
    localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
    localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
    localparam logic [2:0] CMD_DEL_POS  = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_POS_LOW  = 3'd1;
    localparam logic [2:0] ST_POS_OOB  = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // which index the predecessor walk stops at
    typedef enum logic [1:0] {
        KSEL_ZERO   = 2'd0,
        KSEL_LEN    = 2'd1,
        KSEL_LEN_M1 = 2'd2,
        KSEL_POS_M1 = 2'd3
    } ksel_t;

    // controller to datapath
    typedef struct packed {
        logic       init_wr;
        logic       load_item;
        logic       setup;
        ksel_t      ksel;
        logic [2:0] set_status;
        logic       walk;
        logic       ins_a;
        logic       ins_b;
        logic       del_a;
        logic       del_b;
        logic       del_c;
        logic       load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       init_last;
        logic       len_zero;
        logic       pool_full;
        logic       pos_zero;
        logic       pos_one;
        logic       pos_gt_len;
        logic       pos_gt_len1;
        logic       walk_done;
        logic       out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/plle_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module plle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/plle_ctrl.sv
// sequencing state machine for the linked list engine
`default_nettype none

module plle_ctrl import plle_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t sts,
    output dp_cmd_t       ctl
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_CHECK  = 10'b00_0000_0100,
        S_WALK   = 10'b00_0000_1000,
        S_INS_A  = 10'b00_0001_0000,
        S_INS_B  = 10'b00_0010_0000,
        S_DEL_A  = 10'b00_0100_0000,
        S_DEL_B  = 10'b00_1000_0000,
        S_DEL_C  = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   is_insert;
    logic   fail;

    assign s_tready  = (state_reg == S_IDLE);
    assign is_insert = (sts.cmd == CMD_INS_HEAD) || (sts.cmd == CMD_INS_TAIL) ||
                       (sts.cmd == CMD_INS_POS);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        fail       = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                ctl.init_wr = 1'b1;
                if (sts.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                ctl.setup = 1'b1;
                fail      = 1'b1;
                unique case (sts.cmd)
                    CMD_INS_HEAD: begin
                        ctl.ksel = KSEL_ZERO;
                        if (sts.pool_full) ctl.set_status = ST_FULL;
                        else fail = 1'b0;
                    end
                    CMD_INS_TAIL: begin
                        ctl.ksel = KSEL_LEN;
                        if (sts.pool_full) ctl.set_status = ST_FULL;
                        else fail = 1'b0;
                    end
                    CMD_INS_POS: begin
                        ctl.ksel = KSEL_POS_M1;
                        priority if (sts.pos_zero)    ctl.set_status = ST_POS_LOW;
                        else if (sts.pos_gt_len1)     ctl.set_status = ST_POS_OOB;
                        else if (sts.pool_full)       ctl.set_status = ST_FULL;
                        else                          fail = 1'b0;
                    end
                    CMD_DEL_HEAD: begin
                        ctl.ksel = KSEL_ZERO;
                        if (sts.len_zero) ctl.set_status = ST_EMPTY;
                        else fail = 1'b0;
                    end
                    CMD_DEL_TAIL: begin
                        ctl.ksel = KSEL_LEN_M1;
                        if (sts.len_zero) ctl.set_status = ST_EMPTY;
                        else fail = 1'b0;
                    end
                    CMD_DEL_POS: begin
                        ctl.ksel = KSEL_POS_M1;
                        priority if (sts.pos_zero)            ctl.set_status = ST_POS_LOW;
                        else if (sts.pos_one && sts.len_zero) ctl.set_status = ST_EMPTY;
                        else if (sts.pos_gt_len)              ctl.set_status = ST_POS_OOB;
                        else                                  fail = 1'b0;
                    end
                    default: begin
                        // unknown command: report ok, touch nothing
                        ctl.set_status = ST_OK;
                    end
                endcase
                state_next = fail ? S_FINISH : S_WALK;
            end
            S_WALK: begin
                ctl.walk = 1'b1;
                if (sts.walk_done) begin
                    state_next = is_insert ? S_INS_A : S_DEL_A;
                end
            end
            S_INS_A: begin
                ctl.ins_a  = 1'b1;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                ctl.ins_b  = 1'b1;
                state_next = S_FINISH;
            end
            S_DEL_A: begin
                ctl.del_a  = 1'b1;
                state_next = S_DEL_B;
            end
            S_DEL_B: begin
                ctl.del_b  = 1'b1;
                state_next = S_DEL_C;
            end
            S_DEL_C: begin
                ctl.del_c  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/plle_dp.sv
// node pool, list pointers, chain walker and result register
`default_nettype none

module plle_dp import plle_pkg::*; #(
    parameter int POOL_NODES = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [2:0]                           in_cmd,
    input  wire logic signed [31:0]                   in_value,
    input  wire logic [7:0]                           in_position,
    input  wire dp_cmd_t                              ctl,
    output dp_stat_t                                  sts,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output logic [2:0]                                out_status,
    output logic [$clog2(POOL_NODES+1)-1:0]           out_count,
    output logic signed [31:0]                        out_removed
);

    localparam int AW    = $clog2(POOL_NODES);
    localparam int IW    = $clog2(POOL_NODES + 1);
    localparam int CMP_W = ((IW > 8) ? IW : 8) + 1;
    localparam logic [IW-1:0] NONE = IW'(POOL_NODES);

    // list and free chain pointers
    logic [IW-1:0] head_reg, free_head_reg, len_reg;
    logic [AW-1:0] init_cnt_reg;
    logic          out_valid_reg;

    // per item working registers
    logic [2:0]         cmd_reg;
    logic signed [31:0] value_reg;
    logic [7:0]         pos_reg;
    logic [IW-1:0]      cur_reg, hold_reg, remain_reg;
    logic               prev_none_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] removed_reg;
    logic [2:0]         out_status_reg;
    logic [IW-1:0]      out_count_reg;
    logic signed [31:0] out_removed_reg;

    logic [CMP_W-1:0] pos_ext, len_ext;
    logic [IW-1:0]    k;
    logic             walk_done;

    logic                  link_we;
    logic [AW-1:0]         link_waddr, link_raddr;
    logic [IW-1:0]         link_wdata, link_rdata;
    logic [VALUE_BITS-1:0] value_rdata;

    assign pos_ext   = CMP_W'(pos_reg);
    assign len_ext   = CMP_W'(len_reg);
    assign walk_done = prev_none_reg || (remain_reg == IW'(1));

    always_comb begin
        unique case (ctl.ksel)
            KSEL_ZERO:   k = '0;
            KSEL_LEN:    k = len_reg;
            KSEL_LEN_M1: k = len_reg - IW'(1);
            KSEL_POS_M1: k = IW'(pos_ext - CMP_W'(1));
        endcase
    end

    assign sts.cmd         = cmd_reg;
    assign sts.init_last   = (init_cnt_reg == AW'(POOL_NODES - 1));
    assign sts.len_zero    = (len_reg == '0);
    assign sts.pool_full   = (len_reg == NONE);
    assign sts.pos_zero    = (pos_reg == 8'd0);
    assign sts.pos_one     = (pos_reg == 8'd1);
    assign sts.pos_gt_len  = (pos_ext > len_ext);
    assign sts.pos_gt_len1 = (pos_ext > (len_ext + CMP_W'(1)));
    assign sts.walk_done   = walk_done;
    assign sts.out_busy    = out_valid_reg && !out_ready;

    // link port selection
    always_comb begin
        link_raddr = cur_reg[AW-1:0];
        priority if (ctl.setup) link_raddr = head_reg[AW-1:0];
        else if (ctl.walk)      link_raddr = link_rdata[AW-1:0];
        else if (ctl.ins_a)     link_raddr = free_head_reg[AW-1:0];
        else if (ctl.del_a)     link_raddr = hold_reg[AW-1:0];
        else                    link_raddr = cur_reg[AW-1:0];
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        priority if (ctl.init_wr) begin
            link_we    = 1'b1;
            link_waddr = init_cnt_reg;
            link_wdata = IW'(init_cnt_reg) + IW'(1);
        end else if (ctl.ins_a && !prev_none_reg) begin
            link_we    = 1'b1;
            link_waddr = cur_reg[AW-1:0];
            link_wdata = free_head_reg;
        end else if (ctl.ins_b) begin
            link_we    = 1'b1;
            link_waddr = free_head_reg[AW-1:0];
            link_wdata = hold_reg;
        end else if (ctl.del_b && !prev_none_reg) begin
            link_we    = 1'b1;
            link_waddr = cur_reg[AW-1:0];
            link_wdata = link_rdata;
        end else if (ctl.del_c) begin
            link_we    = 1'b1;
            link_waddr = hold_reg[AW-1:0];
            link_wdata = free_head_reg;
        end else begin
            link_we    = 1'b0;
        end
    end

    plle_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    plle_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (POOL_NODES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ctl.ins_a),
        .waddr (free_head_reg[AW-1:0]),
        .wdata (VALUE_BITS'(value_reg)),
        .raddr (hold_reg[AW-1:0]),
        .rdata (value_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= NONE;
            free_head_reg <= '0;
            len_reg       <= '0;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.init_wr) begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (ctl.ins_a && prev_none_reg) begin
                head_reg <= free_head_reg;
            end
            if (ctl.ins_b) begin
                free_head_reg <= link_rdata;
                len_reg       <= len_reg + IW'(1);
            end
            if (ctl.del_b) begin
                if (prev_none_reg) begin
                    head_reg <= link_rdata;
                end
                len_reg <= len_reg - IW'(1);
            end
            if (ctl.del_c) begin
                free_head_reg <= hold_reg;
            end
            if (ctl.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_item) begin
            cmd_reg   <= in_cmd;
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
        if (ctl.setup) begin
            cur_reg       <= head_reg;
            remain_reg    <= k;
            prev_none_reg <= (k == '0);
            status_reg    <= ctl.set_status;
            removed_reg   <= '0;
        end
        if (ctl.walk) begin
            if (walk_done) begin
                // successor of the predecessor, or the head when there is none
                hold_reg <= prev_none_reg ? head_reg : link_rdata;
            end else begin
                cur_reg    <= link_rdata;
                remain_reg <= remain_reg - IW'(1);
            end
        end
        if (ctl.del_b) begin
            removed_reg <= 32'(value_rdata);
        end
        if (ctl.load_out) begin
            out_status_reg  <= status_reg;
            out_count_reg   <= len_reg;
            out_removed_reg <= removed_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_count   = out_count_reg;
    assign out_removed = out_removed_reg;

    a_len_up: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins_b |=> (len_reg == $past(len_reg) + IW'(1)))
        else $error("insert did not grow the list by one");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over a waiting result");

    a_walk_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.walk && !walk_done) |-> (link_rdata != NONE))
        else $error("chain walk ran off the end of the list");

endmodule

`default_nettype wire

// File: src/positional_linked_list_engine.sv
// top level of the positional linked list engine
`default_nettype none

// Singly linked list over a pool of POOL_NODES nodes, one command per input
// item and exactly one result item per command. Commands insert at the head,
// the tail or a 1-based position, or delete from the head, the tail or a
// position; the result carries a status, the list length afterwards and the
// removed value. An accepted item passes through a check state, a chain walk
// of k nodes to the predecessor of the affected node (0 for head commands, up
// to POOL_NODES - 1 for a tail or positional command on a nearly full list),
// the insert states INS_A and INS_B or the delete states DEL_A, DEL_B and
// DEL_C, and a finish state before s_tready is high again; a command that
// fails its checks or is unknown goes from the check straight to finish. The
// walk is one node per cycle, bounded by the single read port of the link
// memory. A result waits in an output register, so the next item is taken
// while it is pending; only a second result that finds the register still
// occupied holds the block. After reset a clearing pass over all POOL_NODES
// nodes builds the free chain in the link memory, and s_tready stays low
// during it.
module positional_linked_list_engine import plle_pkg::*; #(
    parameter int POOL_NODES = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // command input
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [39:0]         s_tdata,   // item_value [31:0], position [39:32]
    input  wire logic [2:0]          s_tuser,   // cmd [2:0]

    // result output
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [((3 + $clog2(POOL_NODES + 1) + 32 + 7) / 8) * 8 - 1:0] m_tdata
    // m_tdata: status [2:0], element_count [next CNT_W bits], removed_value
    // [next 32 bits], zero fill to whole bytes
);

    localparam int CNT_W    = $clog2(POOL_NODES + 1);
    localparam int M_DATA_W = ((3 + CNT_W + 32 + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - (3 + CNT_W + 32);

    // control and status between sequencer and datapath
    dp_cmd_t  ctl;
    dp_stat_t sts;

    // result fields
    logic [2:0]         res_status;
    logic [CNT_W-1:0]   res_count;
    logic signed [31:0] res_removed;

    plle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    plle_dp #(
        .POOL_NODES (POOL_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_cmd      (s_tuser),
        .in_value    (s_tdata[31:0]),
        .in_position (s_tdata[39:32]),
        .ctl         (ctl),
        .sts         (sts),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (res_status),
        .out_count   (res_count),
        .out_removed (res_removed)
    );

    // pack the result item, lowest field first, zero fill on top
    generate
        if (M_PAD_W > 0) begin : g_pad
            assign m_tdata = {{M_PAD_W{1'b0}}, res_removed, res_count, res_status};
        end else begin : g_nopad
            assign m_tdata = {res_removed, res_count, res_status};
        end
    endgenerate

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for the positional linked list engine
`timescale 1ns / 100ps

module tb;
    import plle_pkg::*;

    localparam int POOL_NODES = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(POOL_NODES + 1);
    localparam int RES_W      = ((3 + CNT_W + 32 + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT = 400000;

    // command codes the block does not define, expected to be no-ops
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]        status;
        logic [CNT_W-1:0]  count;
        logic [31:0]       removed;
    } list_result_t;

    // tracks list contents in order and the results the block owes
    class list_scoreboard;
        logic [31:0]  contents[$];
        list_result_t owed[$];
        int           mismatches;

        function void note_command(logic [2:0] cmd, logic [31:0] value, logic [7:0] pos);
            int           len;
            int           idx;
            list_result_t res;
            len = contents.size();
            idx = int'(pos);
            res.status  = ST_OK;
            res.removed = '0;
            case (cmd)
                CMD_INS_HEAD: begin
                    if (len >= POOL_NODES) res.status = ST_FULL;
                    else contents.push_front(value);
                end
                CMD_INS_TAIL: begin
                    if (len >= POOL_NODES) res.status = ST_FULL;
                    else contents.push_back(value);
                end
                CMD_INS_POS: begin
                    // position checks win over the full-pool check
                    if (idx < 1) res.status = ST_POS_LOW;
                    else if (idx > len + 1) res.status = ST_POS_OOB;
                    else if (len >= POOL_NODES) res.status = ST_FULL;
                    else contents.insert(idx - 1, value);
                end
                CMD_DEL_HEAD: begin
                    if (len == 0) res.status = ST_EMPTY;
                    else res.removed = contents.pop_front();
                end
                CMD_DEL_TAIL: begin
                    if (len == 0) res.status = ST_EMPTY;
                    else res.removed = contents.pop_back();
                end
                CMD_DEL_POS: begin
                    if (idx < 1) res.status = ST_POS_LOW;
                    else if (idx == 1 && len == 0) res.status = ST_EMPTY;
                    else if (idx > len) res.status = ST_POS_OOB;
                    else begin
                        res.removed = contents[idx - 1];
                        contents.delete(idx - 1);
                    end
                end
                default: ;
            endcase
            res.count = CNT_W'(contents.size());
            owed.push_back(res);
        endfunction

        function void check_result(logic [RES_W-1:0] data);
            list_result_t want;
            logic [2:0]       got_status;
            logic [CNT_W-1:0] got_count;
            logic [31:0]      got_removed;
            got_status  = data[2:0];
            got_count   = data[3 +: CNT_W];
            got_removed = data[3 + CNT_W +: 32];
            if (owed.size() == 0) begin
                $error("result item with no command pending: status %0d count %0d removed %0h",
                       got_status, got_count, got_removed);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                mismatches++;
            end
            if (got_count !== want.count) begin
                $error("element_count: expected %0d, actual %0d", want.count, got_count);
                mismatches++;
            end
            if (got_removed !== want.removed) begin
                $error("removed_value: expected %0h, actual %0h", want.removed, got_removed);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata = '0;     // item_value [31:0], position [39:32]
    logic [2:0]       s_tuser = '0;     // cmd [2:0]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;          // status [2:0], element_count, removed_value

    int idle_pct  = 0;   // chance per cycle the sender sits idle
    int stall_pct = 0;   // chance per cycle the receiver stalls
    logic hold_req = 1'b0;
    logic hold_off = 1'b0;
    int cycle_count = 0;

    list_scoreboard sb = new();

    positional_linked_list_engine #(
        .POOL_NODES(POOL_NODES),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // run time guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
        end
    end

    // offer one item, with a random idle gap first; valid stays high after accept
    task automatic send_item(input logic [2:0] cmd, input logic [31:0] value,
                             input logic [7:0] pos);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pos, value};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, value, pos);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] corner[4];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        if ($urandom_range(9) == 0) return corner[$urandom_range(3)];
        return $urandom;
    endfunction

    // one random command, insert-heavy or delete-heavy depending on ins_pct
    task automatic random_item(input int ins_pct);
        int          len;
        int          roll;
        logic [2:0]  cmd;
        logic [7:0]  pos;
        logic [2:0]  ins_codes[3];
        logic [2:0]  del_codes[3];
        ins_codes = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS};
        del_codes = '{CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS};
        len = sb.contents.size();
        roll = $urandom_range(99);
        if (roll < 3) cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else if ($urandom_range(99) < ins_pct) cmd = ins_codes[$urandom_range(2)];
        else cmd = del_codes[$urandom_range(2)];
        // mostly in-range positions, some just outside, some anywhere
        roll = $urandom_range(99);
        if (roll < 8) pos = 8'($urandom_range(255));
        else if (roll < 16) pos = 8'($urandom_range(len + 2));
        else pos = 8'($urandom_range(len + 1, 1));
        send_item(cmd, pick_value(), pos);
    endtask

    task automatic directed_items();
        int k;
        // everything that can go wrong on an empty list
        send_item(CMD_DEL_HEAD, 32'h1234_5678, 8'd0);
        send_item(CMD_DEL_TAIL, 32'h0, 8'd0);
        send_item(CMD_DEL_POS, 32'h0, 8'd1);
        send_item(CMD_DEL_POS, 32'h0, 8'd0);
        send_item(CMD_DEL_POS, 32'h0, 8'd2);
        send_item(CMD_INS_POS, 32'h0, 8'd0);
        send_item(CMD_INS_POS, 32'h0, 8'd2);
        send_item(CMD_SPARE_HI, 32'hffff_ffff, 8'hff);
        // fill the pool, mixing head, tail, append and random in-list positions
        send_item(CMD_INS_HEAD, 32'h8000_0000, 8'd0);
        for (k = 1; k < POOL_NODES; k++) begin
            case (k % 4)
                0: send_item(CMD_INS_HEAD, pick_value(), 8'd0);
                1: send_item(CMD_INS_TAIL, 32'h7fff_ffff, 8'd0);
                2: send_item(CMD_INS_POS, pick_value(), 8'(k + 1));
                default: send_item(CMD_INS_POS, pick_value(), 8'($urandom_range(k, 1)));
            endcase
        end
        // full pool: position check first, then full, then out-of-range and valid deletes
        send_item(CMD_INS_POS, 32'h5a5a_5a5a, 8'd0);
        send_item(CMD_INS_TAIL, 32'ha5a5_a5a5, 8'd0);
        send_item(CMD_DEL_POS, 32'h0, 8'(POOL_NODES + 1));
        send_item(CMD_DEL_POS, 32'h0, 8'(POOL_NODES));
        send_item(CMD_DEL_TAIL, 32'h0, 8'd0);
    endtask

    initial begin
        int phase;
        int i;
        int ins_pct;
        int pct_choices[4];
        int idle_sel[4];
        int stall_sel[4];
        pct_choices = '{25, 50, 75, 90};
        idle_sel    = '{0, 53, 0, 9};
        stall_sel   = '{0, 0, 53, 9};
        ins_pct = 50;

        // reset once, then the block runs its clearing pass with s_tready low
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        wait_results_done();

        for (phase = 0; phase < 4; phase++) begin
            idle_pct  <= idle_sel[phase];
            stall_pct <= stall_sel[phase];
            // receiver-stall phase starts with a long hold-off to back up the block
            if (phase == 2) hold_req <= 1'b1;
            @(posedge aclk);
            // one-cycle request pulse, seen by the hold-off process at that edge
            hold_req <= 1'b0;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) ins_pct = pct_choices[$urandom_range(3)];
                random_item(ins_pct);
            end
            // sender pauses until the block has answered everything
            wait_results_done();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
src/plle_pkg.sv
src/plle_ram.sv
src/plle_ctrl.sv
src/plle_dp.sv
src/positional_linked_list_engine.sv
tb/sv/tb.sv
